// ----- rtl/core/dwc_pkg.sv -----
package dwc_pkg;

  localparam int FRAC_W     = 16;
  localparam int MAP_DIM    = 32;
  localparam int MAP_AW     = $clog2(MAP_DIM);
  localparam int GRID_AW    = 2 * MAP_AW;
  localparam int GRID_DEPTH = MAP_DIM * MAP_DIM;
  localparam int CELL_W     = 4;
  localparam int TEX_SIZE   = 64;
  localparam int TEX_W      = $clog2(TEX_SIZE);
  localparam int MAX_SCREEN = 2048;

  // Shared divider: dividend and quotient width, divisor width.
  localparam int DVD_W = 34;
  localparam int DSR_W = 42;
  // Accumulated side distances along the walk.
  localparam int SD_W  = 42;

  localparam logic [DVD_W-1:0] DELTA_INF = DVD_W'(1) << (2 * FRAC_W + 1);
  localparam logic [DVD_W-1:0] ONE_SQ    = DVD_W'(1) << (2 * FRAC_W);
  localparam logic [DVD_W-1:0] TEX_NUM   = DVD_W'(TEX_SIZE) << FRAC_W;
  localparam logic [21:0]      DIST_SAT  = 22'd4194303;
  localparam logic [22:0]      STEP_SAT  = 23'd4194304;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_CAST  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    REG_POS_X   = 3'd0,
    REG_POS_Y   = 3'd1,
    REG_DIR_X   = 3'd2,
    REG_DIR_Y   = 3'd3,
    REG_PLANE_X = 3'd4,
    REG_PLANE_Y = 3'd5,
    REG_COLS    = 3'd6,
    REG_ROWS    = 3'd7
  } reg_e;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

endpackage

// ----- rtl/core/dwc_divider.sv -----
module dwc_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dwc_pkg::div_req_t         req_i,
  output logic                      done_o,
  output logic [dwc_pkg::DVD_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(dwc_pkg::DVD_W + 1);

  logic [dwc_pkg::DSR_W-1:0] rem_q;
  logic [dwc_pkg::DSR_W-1:0] dsr_q;
  logic [dwc_pkg::DVD_W-1:0] quo_q;
  logic [CNT_W-1:0]          cnt_q;
  logic                      busy_q;
  logic                      done_q;
  logic [dwc_pkg::DSR_W:0]   trial;
  logic                      fits;

  // Restoring division, one quotient bit per cycle; the dividend shifts out
  // of quo_q as the quotient shifts in.
  always_comb begin
    trial = {rem_q, quo_q[dwc_pkg::DVD_W-1]};
    fits  = trial >= {1'b0, dsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      dsr_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        rem_q  <= '0;
        dsr_q  <= req_i.divisor;
        quo_q  <= req_i.dividend;
        cnt_q  <= CNT_W'(dwc_pkg::DVD_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= fits ? dwc_pkg::DSR_W'(trial - {1'b0, dsr_q}) : trial[dwc_pkg::DSR_W-1:0];
        quo_q <= {quo_q[dwc_pkg::DVD_W-2:0], fits};
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/core/dwc_grid.sv -----
module dwc_grid (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  output logic                        ready_o,
  input  logic                        we_i,
  input  logic [dwc_pkg::GRID_AW-1:0] waddr_i,
  input  logic [dwc_pkg::CELL_W-1:0]  wdata_i,
  input  logic [dwc_pkg::GRID_AW-1:0] raddr_i,
  output logic [dwc_pkg::CELL_W-1:0]  rdata_o
);

  logic [dwc_pkg::CELL_W-1:0]  cells_q [dwc_pkg::GRID_DEPTH];
  logic [dwc_pkg::CELL_W-1:0]  rdata_q;
  logic [dwc_pkg::GRID_AW-1:0] clr_cnt_q;
  logic                        clr_busy_q;

  // After reset every cell is swept to open, one cell per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + dwc_pkg::GRID_AW'(1);
      if (clr_cnt_q == '1) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      cells_q[clr_cnt_q] <= '0;
    end else if (we_i) begin
      cells_q[waddr_i] <= wdata_i;
    end
    rdata_q <= cells_q[raddr_i];
  end

  assign ready_o = !clr_busy_q;
  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/dda_wall_column_caster_unit.sv -----
// Map write: accepted when idle, no result.
// Column cast: the walk steps at most 64 cells, and the next transaction is accepted in the
// cycle after the result is loaded; one shared radix-2 divider serves up to five divisions
// per column.
// Reset: asynchronous, active low; registers return to their defaults and the map is
// swept to open, during which no input transaction is accepted.
module dda_wall_column_caster_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [10:0] column_i,
  input  logic [4:0]  cell_x_i,
  input  logic [4:0]  cell_y_i,
  input  logic [3:0]  cell_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [10:0] cast_column_o,
  output logic [4:0]  hit_x_o,
  output logic [4:0]  hit_y_o,
  output logic        hit_side_o,
  output logic [3:0]  wall_texture_o,
  output logic [21:0] wall_distance_o,
  output logic [10:0] line_top_o,
  output logic [10:0] line_bottom_o,
  output logic [5:0]  texture_col_o,
  output logic [22:0] texture_step_o,
  output logic [22:0] texture_start_o,
  output logic        escaped_o
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CAM, S_MRX, S_MRY, S_RYC, S_DDX, S_DDY,
    S_SXH, S_SXL, S_SYH, S_SYL, S_SYE, S_WALK, S_WCHK, S_LH,
    S_GEOM, S_STP, S_MST, S_MT1, S_MT2, S_TXE, S_DONE
  } state_e;

  state_e state_q;

  logic [20:0] pos_x_q, pos_y_q;
  logic [17:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
  logic [11:0] cols_q, rows_q;

  logic [10:0]                col_q;
  logic signed [29:0]         cam_q;
  logic signed [32:0]         rdx_q, rdy_q;
  logic [dwc_pkg::DVD_W-1:0]  ddx_q, ddy_q;
  logic [dwc_pkg::SD_W-1:0]   sdx_q, sdy_q, perp_q;
  logic [6:0]                 mx_q, my_q;
  logic [6:0]                 step_cnt_q;
  logic                       side_q;
  logic [3:0]                 cell_q;
  logic [27:0]                lh_q;
  logic [10:0]                top_q, bot_q;
  logic [26:0]                diff_q;
  logic [22:0]                stp_q, start_q;
  logic [15:0]                t1_q;
  logic [5:0]                 tx_q;
  logic                       esc_q;
  logic                       div_run_q;
  logic signed [57:0]         prod_q;

  logic                       out_valid_q;
  logic [10:0]                o_col_q, o_top_q, o_bot_q;
  logic [4:0]                 o_hx_q, o_hy_q;
  logic                       o_side_q, o_esc_q;
  logic [3:0]                 o_tex_q;
  logic [21:0]                o_dist_q;
  logic [5:0]                 o_tx_q;
  logic [22:0]                o_stp_q, o_start_q;

  logic                       cfg_wr;
  logic                       in_acc;
  logic [11:0]                cols_eff, rows_eff;
  logic [32:0]                adx_w, ady_w;
  logic [16:0]                ax, ay;
  logic signed [33:0]         mul_a;
  logic signed [23:0]         mul_b;
  logic signed [57:0]         prod;
  logic                       step_x;
  logic [6:0]                 nmx, nmy;
  logic                       walk_out;
  logic signed [32:0]         tex_r;
  logic [20:0]                tex_base;
  logic [15:0]                frac;
  logic [5:0]                 tx_raw;
  logic                       mirror;
  logic [26:0]                lh2;
  logic [10:0]                half;
  logic [27:0]                bsum;
  logic [dwc_pkg::CELL_W-1:0] grid_rdata;
  logic                       grid_ready;
  logic                       grid_we;
  dwc_pkg::div_req_t          div_req;
  logic                       div_done;
  logic [dwc_pkg::DVD_W-1:0]  div_quo;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc = in_valid_i && !in_stall_o;
  assign grid_we = in_acc && (operation_i == dwc_pkg::OP_WRITE);

  always_comb begin
    unique case (dwc_pkg::reg_e'(paddr[4:2]))
      dwc_pkg::REG_POS_X:   prdata = 32'(pos_x_q);
      dwc_pkg::REG_POS_Y:   prdata = 32'(pos_y_q);
      dwc_pkg::REG_DIR_X:   prdata = 32'(dir_x_q);
      dwc_pkg::REG_DIR_Y:   prdata = 32'(dir_y_q);
      dwc_pkg::REG_PLANE_X: prdata = 32'(plane_x_q);
      dwc_pkg::REG_PLANE_Y: prdata = 32'(plane_y_q);
      dwc_pkg::REG_COLS:    prdata = 32'(cols_q);
      dwc_pkg::REG_ROWS:    prdata = 32'(rows_q);
      default:              prdata = '0;
    endcase
  end

  always_comb begin
    if (cols_q == '0) begin
      cols_eff = 12'd1;
    end else if (cols_q > 12'(dwc_pkg::MAX_SCREEN)) begin
      cols_eff = 12'(dwc_pkg::MAX_SCREEN);
    end else begin
      cols_eff = cols_q;
    end
    if (rows_q == '0) begin
      rows_eff = 12'd1;
    end else if (rows_q > 12'(dwc_pkg::MAX_SCREEN)) begin
      rows_eff = 12'(dwc_pkg::MAX_SCREEN);
    end else begin
      rows_eff = rows_q;
    end
  end

  always_comb begin
    adx_w = rdx_q[32] ? 33'(-rdx_q) : 33'(rdx_q);
    ady_w = rdy_q[32] ? 33'(-rdy_q) : 33'(rdy_q);
    // Distance from the camera to the first boundary, as a cell fraction.
    ax = rdx_q[32] ? {1'b0, pos_x_q[15:0]} : 17'h10000 - {1'b0, pos_x_q[15:0]};
    ay = rdy_q[32] ? {1'b0, pos_y_q[15:0]} : 17'h10000 - {1'b0, pos_y_q[15:0]};

    step_x = sdx_q < sdy_q;
    nmx = mx_q;
    nmy = my_q;
    if (step_x) begin
      nmx = rdx_q[32] ? mx_q - 7'd1 : mx_q + 7'd1;
    end else begin
      nmy = rdy_q[32] ? my_q - 7'd1 : my_q + 7'd1;
    end
    // Coordinates run 0..31; minus one wraps to a value with high bits set.
    walk_out = (nmx[6:5] != 2'b00) || (nmy[6:5] != 2'b00);

    tex_r    = side_q ? rdx_q : rdy_q;
    tex_base = side_q ? pos_x_q : pos_y_q;
    frac     = tex_base[15:0] + prod_q[15:0] + t1_q;
    tx_raw   = frac[15:16-dwc_pkg::TEX_W];
    mirror   = (!side_q && !rdx_q[32] && (rdx_q != '0)) || (side_q && rdy_q[32]);

    lh2  = lh_q[27:1];
    half = rows_eff[11:1];
    bsum = {1'b0, lh2} + 28'(half);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_MRX: begin
        mul_a = 34'(cam_q);
        mul_b = 24'($signed(plane_x_q));
      end
      S_MRY: begin
        mul_a = 34'(cam_q);
        mul_b = 24'($signed(plane_y_q));
      end
      S_SXH: begin
        mul_a = {16'b0, ddx_q[33:16]};
        mul_b = {7'b0, ax};
      end
      S_SXL: begin
        mul_a = {18'b0, ddx_q[15:0]};
        mul_b = {7'b0, ax};
      end
      S_SYH: begin
        mul_a = {16'b0, ddy_q[33:16]};
        mul_b = {7'b0, ay};
      end
      S_SYL: begin
        mul_a = {18'b0, ddy_q[15:0]};
        mul_b = {7'b0, ay};
      end
      S_MST: begin
        mul_a = {7'b0, diff_q};
        mul_b = {1'b0, stp_q};
      end
      // Only the low 16 bits of the hit coordinate are needed, so the products
      // are taken modulo 2^32 on the unsigned bit patterns.
      S_MT1: begin
        mul_a = {2'b0, tex_r[31:0]};
        mul_b = {8'b0, perp_q[15:0]};
      end
      S_MT2: begin
        mul_a = {18'b0, perp_q[31:16]};
        mul_b = {8'b0, tex_r[15:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    div_req = '0;
    unique case (state_q)
      S_CAM: begin
        div_req.start    = !div_run_q;
        div_req.dividend = dwc_pkg::DVD_W'({col_q, 17'b0});
        div_req.divisor  = dwc_pkg::DSR_W'(cols_eff);
      end
      S_DDX: begin
        div_req.start    = !div_run_q && (adx_w != '0);
        div_req.dividend = dwc_pkg::ONE_SQ;
        div_req.divisor  = dwc_pkg::DSR_W'(adx_w);
      end
      S_DDY: begin
        div_req.start    = !div_run_q && (ady_w != '0);
        div_req.dividend = dwc_pkg::ONE_SQ;
        div_req.divisor  = dwc_pkg::DSR_W'(ady_w);
      end
      S_LH: begin
        div_req.start    = !div_run_q && (perp_q != '0);
        div_req.dividend = dwc_pkg::DVD_W'({rows_eff, 16'b0});
        div_req.divisor  = perp_q;
      end
      S_STP: begin
        div_req.start    = !div_run_q && (lh_q != '0);
        div_req.dividend = dwc_pkg::TEX_NUM;
        div_req.divisor  = dwc_pkg::DSR_W'(lh_q);
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  dwc_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  dwc_grid u_grid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ready_o (grid_ready),
    .we_i    (grid_we),
    .waddr_i ({cell_x_i, cell_y_i}),
    .wdata_i (cell_value_i),
    .raddr_i ({nmx[4:0], nmy[4:0]}),
    .rdata_o (grid_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      pos_x_q     <= 21'd1441792;
      pos_y_q     <= 21'd753664;
      dir_x_q     <= 18'h30000;
      dir_y_q     <= '0;
      plane_x_q   <= '0;
      plane_y_q   <= 18'd43254;
      cols_q      <= 12'd640;
      rows_q      <= 12'd480;
      col_q       <= '0;
      cam_q       <= '0;
      rdx_q       <= '0;
      rdy_q       <= '0;
      ddx_q       <= '0;
      ddy_q       <= '0;
      sdx_q       <= '0;
      sdy_q       <= '0;
      perp_q      <= '0;
      mx_q        <= '0;
      my_q        <= '0;
      step_cnt_q  <= '0;
      side_q      <= 1'b0;
      cell_q      <= '0;
      lh_q        <= '0;
      top_q       <= '0;
      bot_q       <= '0;
      diff_q      <= '0;
      stp_q       <= '0;
      start_q     <= '0;
      t1_q        <= '0;
      tx_q        <= '0;
      esc_q       <= 1'b0;
      div_run_q   <= 1'b0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
      o_col_q     <= '0;
      o_top_q     <= '0;
      o_bot_q     <= '0;
      o_hx_q      <= '0;
      o_hy_q      <= '0;
      o_side_q    <= 1'b0;
      o_esc_q     <= 1'b0;
      o_tex_q     <= '0;
      o_dist_q    <= '0;
      o_tx_q      <= '0;
      o_stp_q     <= '0;
      o_start_q   <= '0;
    end else begin
      prod_q <= prod;

      if (cfg_wr) begin
        unique case (dwc_pkg::reg_e'(paddr[4:2]))
          dwc_pkg::REG_POS_X:   pos_x_q   <= pwdata[20:0];
          dwc_pkg::REG_POS_Y:   pos_y_q   <= pwdata[20:0];
          dwc_pkg::REG_DIR_X:   dir_x_q   <= pwdata[17:0];
          dwc_pkg::REG_DIR_Y:   dir_y_q   <= pwdata[17:0];
          dwc_pkg::REG_PLANE_X: plane_x_q <= pwdata[17:0];
          dwc_pkg::REG_PLANE_Y: plane_y_q <= pwdata[17:0];
          dwc_pkg::REG_COLS:    cols_q    <= pwdata[11:0];
          dwc_pkg::REG_ROWS:    rows_q    <= pwdata[11:0];
          default: ;
        endcase
      end

      // In S_DONE the output register is reloaded instead.
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_CLEAR: begin
          if (grid_ready) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc && (operation_i == dwc_pkg::OP_CAST)) begin
            col_q   <= column_i;
            esc_q   <= 1'b0;
            state_q <= S_CAM;
          end
        end
        S_CAM: begin
          if (!div_run_q) begin
            div_run_q <= 1'b1;
          end else if (div_done) begin
            div_run_q <= 1'b0;
            cam_q     <= $signed({2'b00, div_quo[27:0]}) - 30'sd65536;
            state_q   <= S_MRX;
          end
        end
        S_MRX: begin
          state_q <= S_MRY;
        end
        S_MRY: begin
          rdx_q   <= 33'($signed(dir_x_q)) + $signed(prod_q[48:16]);
          state_q <= S_RYC;
        end
        S_RYC: begin
          rdy_q   <= 33'($signed(dir_y_q)) + $signed(prod_q[48:16]);
          state_q <= S_DDX;
        end
        S_DDX: begin
          if (!div_run_q) begin
            if (adx_w == '0) begin
              ddx_q   <= dwc_pkg::DELTA_INF;
              state_q <= S_DDY;
            end else begin
              div_run_q <= 1'b1;
            end
          end else if (div_done) begin
            div_run_q <= 1'b0;
            ddx_q     <= div_quo;
            state_q   <= S_DDY;
          end
        end
        S_DDY: begin
          if (!div_run_q) begin
            if (ady_w == '0) begin
              ddy_q   <= dwc_pkg::DELTA_INF;
              state_q <= S_SXH;
            end else begin
              div_run_q <= 1'b1;
            end
          end else if (div_done) begin
            div_run_q <= 1'b0;
            ddy_q     <= div_quo;
            state_q   <= S_SXH;
          end
        end
        S_SXH: begin
          state_q <= S_SXL;
        end
        S_SXL: begin
          sdx_q   <= prod_q[dwc_pkg::SD_W-1:0];
          state_q <= S_SYH;
        end
        S_SYH: begin
          sdx_q   <= sdx_q + dwc_pkg::SD_W'(prod_q[47:16]);
          state_q <= S_SYL;
        end
        S_SYL: begin
          sdy_q   <= prod_q[dwc_pkg::SD_W-1:0];
          state_q <= S_SYE;
        end
        S_SYE: begin
          sdy_q      <= sdy_q + dwc_pkg::SD_W'(prod_q[47:16]);
          mx_q       <= {2'b00, pos_x_q[20:16]};
          my_q       <= {2'b00, pos_y_q[20:16]};
          step_cnt_q <= '0;
          state_q    <= S_WALK;
        end
        S_WALK: begin
          if (step_x) begin
            sdx_q  <= sdx_q + dwc_pkg::SD_W'(ddx_q);
            side_q <= 1'b0;
          end else begin
            sdy_q  <= sdy_q + dwc_pkg::SD_W'(ddy_q);
            side_q <= 1'b1;
          end
          mx_q       <= nmx;
          my_q       <= nmy;
          step_cnt_q <= step_cnt_q + 7'd1;
          if (walk_out) begin
            esc_q   <= 1'b1;
            state_q <= S_DONE;
          end else begin
            state_q <= S_WCHK;
          end
        end
        S_WCHK: begin
          if (grid_rdata != '0) begin
            cell_q  <= grid_rdata;
            perp_q  <= side_q ? sdy_q - dwc_pkg::SD_W'(ddy_q)
                              : sdx_q - dwc_pkg::SD_W'(ddx_q);
            state_q <= S_LH;
          end else if (step_cnt_q == 7'(2 * dwc_pkg::MAP_DIM)) begin
            esc_q   <= 1'b1;
            state_q <= S_DONE;
          end else begin
            state_q <= S_WALK;
          end
        end
        S_LH: begin
          if (!div_run_q) begin
            if (perp_q == '0) begin
              lh_q    <= 28'(rows_eff);
              state_q <= S_GEOM;
            end else begin
              div_run_q <= 1'b1;
            end
          end else if (div_done) begin
            div_run_q <= 1'b0;
            lh_q      <= div_quo[27:0];
            state_q   <= S_GEOM;
          end
        end
        S_GEOM: begin
          if (lh2 > 27'(half)) begin
            top_q  <= '0;
            diff_q <= lh2 - 27'(half);
          end else begin
            top_q  <= 11'(27'(half) - lh2);
            diff_q <= '0;
          end
          bot_q   <= (bsum >= 28'(rows_eff)) ? 11'(rows_eff - 12'd1) : 11'(bsum);
          state_q <= S_STP;
        end
        S_STP: begin
          if (!div_run_q) begin
            if (lh_q == '0) begin
              stp_q   <= dwc_pkg::STEP_SAT;
              state_q <= S_MST;
            end else begin
              div_run_q <= 1'b1;
            end
          end else if (div_done) begin
            div_run_q <= 1'b0;
            stp_q     <= div_quo[22:0];
            state_q   <= S_MST;
          end
        end
        S_MST: begin
          state_q <= S_MT1;
        end
        S_MT1: begin
          start_q <= ($unsigned(prod_q) > 58'(dwc_pkg::STEP_SAT)) ? dwc_pkg::STEP_SAT
                                                                  : prod_q[22:0];
          state_q <= S_MT2;
        end
        S_MT2: begin
          t1_q    <= prod_q[31:16];
          state_q <= S_TXE;
        end
        S_TXE: begin
          tx_q    <= mirror ? ~tx_raw : tx_raw;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            o_col_q     <= col_q;
            o_esc_q     <= esc_q;
            if (esc_q) begin
              o_hx_q    <= '0;
              o_hy_q    <= '0;
              o_side_q  <= 1'b0;
              o_tex_q   <= '0;
              o_dist_q  <= '0;
              o_top_q   <= '0;
              o_bot_q   <= '0;
              o_tx_q    <= '0;
              o_stp_q   <= '0;
              o_start_q <= '0;
            end else begin
              o_hx_q    <= mx_q[4:0];
              o_hy_q    <= my_q[4:0];
              o_side_q  <= side_q;
              o_tex_q   <= cell_q - 4'd1;
              o_dist_q  <= (perp_q > dwc_pkg::SD_W'(dwc_pkg::DIST_SAT)) ? dwc_pkg::DIST_SAT
                                                                          : perp_q[21:0];
              o_top_q   <= top_q;
              o_bot_q   <= bot_q;
              o_tx_q    <= tx_q;
              o_stp_q   <= stp_q;
              o_start_q <= start_q;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cast_column_o   = o_col_q;
  assign hit_x_o         = o_hx_q;
  assign hit_y_o         = o_hy_q;
  assign hit_side_o      = o_side_q;
  assign wall_texture_o  = o_tex_q;
  assign wall_distance_o = o_dist_q;
  assign line_top_o      = o_top_q;
  assign line_bottom_o   = o_bot_q;
  assign texture_col_o   = o_tx_q;
  assign texture_step_o  = o_stp_q;
  assign texture_start_o = o_start_q;
  assign escaped_o       = o_esc_q;

endmodule
